// ===== rtl/s2icb_pkg.sv =====
// ----------------------------------------------------------------------------
// s2icb_pkg
// Shared types and codes for the serial to I2C command bridge.
// ----------------------------------------------------------------------------
package s2icb_pkg;

  // event kinds on the input channel
  localparam logic [1:0] EV_SERIAL   = 2'd0;
  localparam logic [1:0] EV_BUS_DONE = 2'd1;
  localparam logic [1:0] EV_TICK     = 2'd2;
  localparam logic [1:0] EV_LINK_ERR = 2'd3;

  // parser phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  // kind of bus request awaiting completion
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_ADDR = 2'd1;
  localparam logic [1:0] PK_DATA = 2'd2;
  localparam logic [1:0] PK_READ = 2'd3;

  // bus requests
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // command characters
  localparam logic [7:0] CH_START  = 8'h53;
  localparam logic [7:0] CH_STOP   = 8'h50;
  localparam logic [7:0] CH_ERRORS = 8'h45;

  // sticky error flag bits
  localparam int unsigned ERR_W = 7;
  localparam logic [ERR_W-1:0] EF_NACK_ADDR     = 7'h01;
  localparam logic [ERR_W-1:0] EF_NACK_DATA     = 7'h02;
  localparam logic [ERR_W-1:0] EF_BUS_TIMEOUT   = 7'h04;
  localparam logic [ERR_W-1:0] EF_CMD_INVALID   = 7'h08;
  localparam logic [ERR_W-1:0] EF_CMD_TIMEOUT   = 7'h10;
  localparam logic [ERR_W-1:0] EF_LINK_OVERFLOW = 7'h20;
  localparam logic [ERR_W-1:0] EF_LINK_FRAMING  = 7'h40;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       data_byte;
    logic             bus_nack;
    logic             bus_timeout;
    logic [7:0]       bus_read_data;
    logic             link_overflow;
    logic             link_framing;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_op;
    logic [7:0] bus_write_data;
    logic       read_last;
    logic       reply_valid;
    logic [7:0] reply_data;
  } result_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic             xact_open;
    logic             read_dir;
    logic [7:0]       bytes_left;
    logic [ERR_W-1:0] err_flags;
    logic [15:0]      idle_ms;
    logic [1:0]       pending;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_IDLE,
    xact_open:  1'b0,
    read_dir:   1'b0,
    bytes_left: 8'd0,
    err_flags:  '0,
    idle_ms:    16'd0,
    pending:    PK_NONE
  };

endpackage

// ===== rtl/s2icb_if.sv =====
// ----------------------------------------------------------------------------
// s2icb channel interfaces
// Valid/ready channels for events, results and the timeout register write.
// ----------------------------------------------------------------------------

// event channel
interface s2icb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       bus_nack;
  logic       bus_timeout;
  logic [7:0] bus_read_data;
  logic       link_overflow;
  logic       link_framing;

  modport source (output valid, cmd, data_byte, bus_nack, bus_timeout, bus_read_data,
                  link_overflow, link_framing, input ready);
  modport sink   (input valid, cmd, data_byte, bus_nack, bus_timeout, bus_read_data,
                  link_overflow, link_framing, output ready);
endinterface

// result channel
interface s2icb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_op;
  logic [7:0] bus_write_data;
  logic       read_last;
  logic       reply_valid;
  logic [7:0] reply_data;

  modport source (output valid, bus_op, bus_write_data, read_last, reply_valid,
                  reply_data, input ready);
  modport sink   (input valid, bus_op, bus_write_data, read_last, reply_valid,
                  reply_data, output ready);
endinterface

// timeout register write channel
interface s2icb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/s2icb_step.sv =====
// ----------------------------------------------------------------------------
// s2icb_step
// Next-state and result logic for one event: parser, bus completion,
// watchdog tick and link error capture.
// ----------------------------------------------------------------------------
module s2icb_step (
  input  s2icb_pkg::state_t  st,
  input  s2icb_pkg::item_t   item,
  input  logic [15:0]        timeout_ms,
  output s2icb_pkg::state_t  st_nxt,
  output s2icb_pkg::result_t res
);

  logic [7:0]  bytes_dec;
  logic [15:0] idle_inc;
  logic        reading;

  // saturating counters (bytes_dec shared by two branches) and the read flag
  assign bytes_dec = (st.bytes_left != 8'd0) ? st.bytes_left - 8'd1 : 8'd0;
  assign idle_inc  = (st.idle_ms != s2icb_pkg::IDLE_MAX) ? st.idle_ms + 16'd1 : st.idle_ms;
  assign reading   = (st.phase == s2icb_pkg::PH_DATA) && st.read_dir;

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (item.cmd)
      // serial command byte
      s2icb_pkg::EV_SERIAL: begin
        st_nxt.idle_ms = '0;
        case (st.phase)
          s2icb_pkg::PH_IDLE: begin
            if (item.data_byte == s2icb_pkg::CH_ERRORS) begin
              res.reply_valid  = 1'b1;
              res.reply_data   = {1'b0, st.err_flags};
              st_nxt.err_flags = '0;
            end else if (item.data_byte == s2icb_pkg::CH_START) begin
              res.bus_op       = s2icb_pkg::OP_START;
              st_nxt.xact_open = 1'b1;
              st_nxt.phase     = s2icb_pkg::PH_ADDR;
            end else if (item.data_byte == s2icb_pkg::CH_STOP && st.xact_open) begin
              res.bus_op       = s2icb_pkg::OP_STOP;
              st_nxt.xact_open = 1'b0;
            end else begin
              st_nxt.err_flags = st.err_flags | s2icb_pkg::EF_CMD_INVALID;
            end
          end
          s2icb_pkg::PH_ADDR: begin
            st_nxt.read_dir    = item.data_byte[0];
            res.bus_op         = s2icb_pkg::OP_WRITE;
            res.bus_write_data = item.data_byte;
            st_nxt.pending     = s2icb_pkg::PK_ADDR;
            st_nxt.phase       = s2icb_pkg::PH_LEN;
          end
          s2icb_pkg::PH_LEN: begin
            st_nxt.bytes_left = item.data_byte;
            if (item.data_byte == 8'd0) begin
              st_nxt.phase = s2icb_pkg::PH_IDLE;
            end else begin
              st_nxt.phase = s2icb_pkg::PH_DATA;
              if (st.read_dir) begin
                res.bus_op     = s2icb_pkg::OP_READ;
                res.read_last  = (item.data_byte == 8'd1);
                st_nxt.pending = s2icb_pkg::PK_READ;
              end
            end
          end
          default: begin
            if (st.read_dir) begin
              st_nxt.err_flags = st.err_flags | s2icb_pkg::EF_CMD_INVALID;
            end else begin
              res.bus_op         = s2icb_pkg::OP_WRITE;
              res.bus_write_data = item.data_byte;
              st_nxt.pending     = s2icb_pkg::PK_DATA;
              st_nxt.bytes_left  = bytes_dec;
              if (bytes_dec == 8'd0) begin
                st_nxt.phase = s2icb_pkg::PH_IDLE;
              end
            end
          end
        endcase
      end
      // completion of the last bus request
      s2icb_pkg::EV_BUS_DONE: begin
        st_nxt.pending = s2icb_pkg::PK_NONE;
        if (item.bus_timeout) begin
          st_nxt.err_flags = st.err_flags | s2icb_pkg::EF_BUS_TIMEOUT;
        end else if (item.bus_nack && st.pending == s2icb_pkg::PK_ADDR) begin
          st_nxt.err_flags = st.err_flags | s2icb_pkg::EF_NACK_ADDR;
        end else if (item.bus_nack && st.pending == s2icb_pkg::PK_DATA) begin
          st_nxt.err_flags = st.err_flags | s2icb_pkg::EF_NACK_DATA;
        end
        if (st.pending == s2icb_pkg::PK_READ) begin
          res.reply_valid   = 1'b1;
          res.reply_data    = item.bus_timeout ? 8'd0 : item.bus_read_data;
          st_nxt.bytes_left = bytes_dec;
          if (bytes_dec == 8'd0) begin
            if (st.phase == s2icb_pkg::PH_DATA) begin
              st_nxt.phase = s2icb_pkg::PH_IDLE;
            end
          end else if (reading) begin
            res.bus_op     = s2icb_pkg::OP_READ;
            res.read_last  = (bytes_dec == 8'd1);
            st_nxt.pending = s2icb_pkg::PK_READ;
          end
        end
      end
      // millisecond tick and watchdog
      s2icb_pkg::EV_TICK: begin
        st_nxt.idle_ms = idle_inc;
        if (!reading && st.xact_open && timeout_ms != 16'd0 && idle_inc > timeout_ms) begin
          res.bus_op       = s2icb_pkg::OP_STOP;
          st_nxt.xact_open = 1'b0;
          st_nxt.err_flags = st.err_flags | s2icb_pkg::EF_CMD_TIMEOUT;
          st_nxt.phase     = s2icb_pkg::PH_IDLE;
          st_nxt.pending   = s2icb_pkg::PK_NONE;
        end
      end
      // serial link error flags
      default: begin
        st_nxt.err_flags = st.err_flags
                         | (item.link_overflow ? s2icb_pkg::EF_LINK_OVERFLOW : '0)
                         | (item.link_framing  ? s2icb_pkg::EF_LINK_FRAMING  : '0);
      end
    endcase
  end

endmodule

// ===== rtl/serial_to_i2c_command_bridge.sv =====
// ----------------------------------------------------------------------------
// serial_to_i2c_command_bridge
// Parses serial commands into I2C bus requests and returns replies.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   event channel: serial byte, bus completion, ms tick or link errors
//   out_ch  one result per event: bus request, write byte, read_last flag,
//           and an optional reply byte for the serial link
//   cfg_ch  write of command_timeout_ms (always ready, write only while idle)
// Pipeline:
//   an accepted event is held in the input register, then its result is
//   loaded into the output register once that register is empty or its
//   result leaves. One event per cycle is sustained while out_ch.ready
//   stays high; the state update for an event is a single pass through
//   the step logic.
// Reset:
//   rst_n low clears both pipeline registers, the parser state and the
//   error flags, and sets the timeout to 500 ms.
// Stalls:
//   while out_ch.ready is low the result is held; the input register still
//   takes one more event, then in_ch.ready drops until the result leaves.
// ----------------------------------------------------------------------------
module serial_to_i2c_command_bridge (
  input  logic          clk,
  input  logic          rst_n,
  s2icb_in_if.sink      in_ch,
  s2icb_out_if.source   out_ch,
  s2icb_cfg_if.sink     cfg_ch
);

  logic                s1_valid_r;
  s2icb_pkg::item_t    s1_item_r;
  logic                s1_adv;
  logic                out_valid_r;
  s2icb_pkg::result_t  out_res_r;
  s2icb_pkg::result_t  res_nxt;
  s2icb_pkg::state_t   state_r;
  s2icb_pkg::state_t   state_nxt;
  logic [15:0]         timeout_r;

  // handshake control
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= s2icb_pkg::TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      timeout_r <= cfg_ch.data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= '{
        cmd:           in_ch.cmd,
        data_byte:     in_ch.data_byte,
        bus_nack:      in_ch.bus_nack,
        bus_timeout:   in_ch.bus_timeout,
        bus_read_data: in_ch.bus_read_data,
        link_overflow: in_ch.link_overflow,
        link_framing:  in_ch.link_framing
      };
    end
  end

  // per-event step logic
  s2icb_step u_step (
    .st         (state_r),
    .item       (s1_item_r),
    .timeout_ms (timeout_r),
    .st_nxt     (state_nxt),
    .res        (res_nxt)
  );

  // bridge state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= s2icb_pkg::STATE_RESET;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bus_op         = out_res_r.bus_op;
  assign out_ch.bus_write_data = out_res_r.bus_write_data;
  assign out_ch.read_last      = out_res_r.read_last;
  assign out_ch.reply_valid    = out_res_r.reply_valid;
  assign out_ch.reply_data     = out_res_r.reply_data;

  // a read in progress always has a read outstanding and bytes to go
  a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == s2icb_pkg::PH_DATA && state_r.read_dir) |->
      (state_r.pending == s2icb_pkg::PK_READ && state_r.bytes_left != 8'd0))
    else $error("read phase without outstanding read");

  // the parser only leaves idle inside an open transaction
  a_phase_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != s2icb_pkg::PH_IDLE) |-> state_r.xact_open)
    else $error("parser busy with no open transaction");

  // an event leaving the input register always lands in the output register
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result lost between stages");

  // timeout register follows the write channel
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid |=> (timeout_r == $past(cfg_ch.data)))
    else $error("timeout register write dropped");

endmodule

// ===== dv/serial_to_i2c_command_bridge_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_to_i2c_command_bridge_checker
// Watches the event, result and timeout write channels of the bridge. Keeps
// its own copy of the parser, watchdog and error flag state, works out the
// bus request and reply for every accepted event, and compares each accepted
// result with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module serial_to_i2c_command_bridge_checker (
  input  logic        clk,
  input  logic        rst_n,
  s2icb_in_if         in_ch,
  s2icb_out_if        out_ch,
  s2icb_cfg_if        cfg_ch,
  output int unsigned fail_count
);

  // predicted bridge state
  logic [1:0]                  phase_q;
  logic                        open_q;
  logic                        read_dir_q;
  logic [7:0]                  left_q;
  logic [s2icb_pkg::ERR_W-1:0] flags_q;
  logic [15:0]                 idle_q;
  logic [1:0]                  pend_q;
  logic [15:0]                 limit_q;

  s2icb_pkg::result_t expected_bus_words[$];
  int unsigned        mismatches;

  // serial command parser
  function automatic s2icb_pkg::result_t parse_serial(input logic [7:0] b);
    s2icb_pkg::result_t r;
    r = '0;
    case (phase_q)
      s2icb_pkg::PH_IDLE: begin
        if (b == s2icb_pkg::CH_ERRORS) begin
          r.reply_valid = 1'b1;
          r.reply_data  = {1'b0, flags_q};
          flags_q       = '0;
        end else if (b == s2icb_pkg::CH_START) begin
          r.bus_op = s2icb_pkg::OP_START;
          open_q   = 1'b1;
          phase_q  = s2icb_pkg::PH_ADDR;
        end else if (b == s2icb_pkg::CH_STOP && open_q) begin
          r.bus_op = s2icb_pkg::OP_STOP;
          open_q   = 1'b0;
        end else begin
          flags_q |= s2icb_pkg::EF_CMD_INVALID;
        end
      end
      s2icb_pkg::PH_ADDR: begin
        read_dir_q       = b[0];
        r.bus_op         = s2icb_pkg::OP_WRITE;
        r.bus_write_data = b;
        pend_q           = s2icb_pkg::PK_ADDR;
        phase_q          = s2icb_pkg::PH_LEN;
      end
      s2icb_pkg::PH_LEN: begin
        left_q = b;
        if (b == 8'd0) begin
          phase_q = s2icb_pkg::PH_IDLE;
        end else begin
          phase_q = s2icb_pkg::PH_DATA;
          if (read_dir_q) begin
            r.bus_op    = s2icb_pkg::OP_READ;
            r.read_last = (b == 8'd1);
            pend_q      = s2icb_pkg::PK_READ;
          end
        end
      end
      default: begin
        // serial bytes are not expected while reading
        if (read_dir_q) begin
          flags_q |= s2icb_pkg::EF_CMD_INVALID;
        end else begin
          r.bus_op         = s2icb_pkg::OP_WRITE;
          r.bus_write_data = b;
          pend_q           = s2icb_pkg::PK_DATA;
          if (left_q != 8'd0) left_q--;
          if (left_q == 8'd0) phase_q = s2icb_pkg::PH_IDLE;
        end
      end
    endcase
    return r;
  endfunction

  // completion of the newest bus request
  function automatic s2icb_pkg::result_t finish_bus_op(input logic nack, input logic tmo,
                                                       input logic [7:0] rd);
    s2icb_pkg::result_t r;
    logic [1:0]         kind;
    r      = '0;
    kind   = pend_q;
    pend_q = s2icb_pkg::PK_NONE;
    if (tmo) flags_q |= s2icb_pkg::EF_BUS_TIMEOUT;
    if (kind == s2icb_pkg::PK_ADDR || kind == s2icb_pkg::PK_DATA) begin
      if (!tmo && nack) begin
        flags_q |= (kind == s2icb_pkg::PK_ADDR) ? s2icb_pkg::EF_NACK_ADDR
                                                : s2icb_pkg::EF_NACK_DATA;
      end
    end else if (kind == s2icb_pkg::PK_READ) begin
      r.reply_valid = 1'b1;
      r.reply_data  = tmo ? 8'd0 : rd;
      if (left_q != 8'd0) left_q--;
      if (left_q == 8'd0) begin
        if (phase_q == s2icb_pkg::PH_DATA) phase_q = s2icb_pkg::PH_IDLE;
      end else if (phase_q == s2icb_pkg::PH_DATA && read_dir_q) begin
        r.bus_op    = s2icb_pkg::OP_READ;
        r.read_last = (left_q == 8'd1);
        pend_q      = s2icb_pkg::PK_READ;
      end
    end
    return r;
  endfunction

  // one event in, one bus request word out
  function automatic s2icb_pkg::result_t decode_event(input s2icb_pkg::item_t ev);
    s2icb_pkg::result_t r;
    r = '0;
    case (ev.cmd)
      s2icb_pkg::EV_SERIAL: begin
        r      = parse_serial(ev.data_byte);
        idle_q = '0;
      end
      s2icb_pkg::EV_BUS_DONE: begin
        r = finish_bus_op(ev.bus_nack, ev.bus_timeout, ev.bus_read_data);
      end
      s2icb_pkg::EV_TICK: begin
        if (idle_q != s2icb_pkg::IDLE_MAX) idle_q++;
        // watchdog, held off while a read is under way
        if (!(phase_q == s2icb_pkg::PH_DATA && read_dir_q) && open_q &&
            limit_q != 16'd0 && idle_q > limit_q) begin
          r.bus_op = s2icb_pkg::OP_STOP;
          open_q   = 1'b0;
          flags_q |= s2icb_pkg::EF_CMD_TIMEOUT;
          phase_q  = s2icb_pkg::PH_IDLE;
          pend_q   = s2icb_pkg::PK_NONE;
        end
      end
      default: begin
        if (ev.link_overflow) flags_q |= s2icb_pkg::EF_LINK_OVERFLOW;
        if (ev.link_framing)  flags_q |= s2icb_pkg::EF_LINK_FRAMING;
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // monitor all three channels at each edge
  always @(posedge clk) begin
    s2icb_pkg::item_t   ev;
    s2icb_pkg::result_t want;
    if (!rst_n) begin
      phase_q    = s2icb_pkg::PH_IDLE;
      open_q     = 1'b0;
      read_dir_q = 1'b0;
      left_q     = '0;
      flags_q    = '0;
      idle_q     = '0;
      pend_q     = s2icb_pkg::PK_NONE;
      limit_q    = s2icb_pkg::TIMEOUT_RESET;
      mismatches = 0;
      expected_bus_words.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) limit_q = cfg_ch.data;

      // result transaction against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bus_words.size() == 0) begin
          $error("result transaction with nothing outstanding");
          mismatches++;
        end else begin
          want = expected_bus_words.pop_front();
          compare_field("bus_op", 8'(want.bus_op), 8'(out_ch.bus_op));
          compare_field("bus_write_data", want.bus_write_data, out_ch.bus_write_data);
          compare_field("read_last", 8'(want.read_last), 8'(out_ch.read_last));
          compare_field("reply_valid", 8'(want.reply_valid), 8'(out_ch.reply_valid));
          compare_field("reply_data", want.reply_data, out_ch.reply_data);
        end
      end

      // event transaction
      if (in_ch.valid && in_ch.ready) begin
        ev.cmd           = in_ch.cmd;
        ev.data_byte     = in_ch.data_byte;
        ev.bus_nack      = in_ch.bus_nack;
        ev.bus_timeout   = in_ch.bus_timeout;
        ev.bus_read_data = in_ch.bus_read_data;
        ev.link_overflow = in_ch.link_overflow;
        ev.link_framing  = in_ch.link_framing;
        expected_bus_words.push_back(decode_event(ev));
      end
    end
    fail_count <= mismatches + expected_bus_words.size();
  end

endmodule

// ===== dv/serial_to_i2c_command_bridge_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_to_i2c_command_bridge_tb
// Drives serial bytes, bus completions, ms ticks and link errors into the
// bridge with random gaps and result stalls: a directed pass over commands,
// flags and the watchdog, then random command sequences under several
// timeouts.
// ----------------------------------------------------------------------------
module serial_to_i2c_command_bridge_tb;

  logic clk;
  logic rst_n;

  s2icb_in_if  in_ch();
  s2icb_out_if out_ch();
  s2icb_cfg_if cfg_ch();

  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned done_count;
  int unsigned stall_left;
  bit          in_no_gap;
  bit          out_no_stall;

  serial_to_i2c_command_bridge dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  serial_to_i2c_command_bridge_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // result side stalls
  always @(posedge clk) begin
    if (out_no_stall) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 15) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // completed result transactions
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) done_count <= done_count + 1;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic s2icb_pkg::item_t random_item();
    logic [31:0] rnd;
    rnd = $urandom;
    return s2icb_pkg::item_t'(rnd[$bits(s2icb_pkg::item_t)-1:0]);
  endfunction

  // one event transaction, valid stays high afterwards
  task automatic send_event(input s2icb_pkg::item_t ev);
    int unsigned gap;
    gap = in_no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= ev.cmd;
    in_ch.data_byte     <= ev.data_byte;
    in_ch.bus_nack      <= ev.bus_nack;
    in_ch.bus_timeout   <= ev.bus_timeout;
    in_ch.bus_read_data <= ev.bus_read_data;
    in_ch.link_overflow <= ev.link_overflow;
    in_ch.link_framing  <= ev.link_framing;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    s2icb_pkg::item_t ev;
    ev           = random_item();
    ev.cmd       = s2icb_pkg::EV_SERIAL;
    ev.data_byte = b;
    send_event(ev);
  endtask

  task automatic send_done(input logic nack, input logic tmo, input logic [7:0] rd);
    s2icb_pkg::item_t ev;
    ev               = random_item();
    ev.cmd           = s2icb_pkg::EV_BUS_DONE;
    ev.bus_nack      = nack;
    ev.bus_timeout   = tmo;
    ev.bus_read_data = rd;
    send_event(ev);
  endtask

  task automatic send_tick();
    s2icb_pkg::item_t ev;
    ev     = random_item();
    ev.cmd = s2icb_pkg::EV_TICK;
    send_event(ev);
  endtask

  task automatic send_link(input logic ovf, input logic frm);
    s2icb_pkg::item_t ev;
    ev               = random_item();
    ev.cmd           = s2icb_pkg::EV_LINK_ERR;
    ev.link_overflow = ovf;
    ev.link_framing  = frm;
    send_event(ev);
  endtask

  // hold off until every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (done_count != sent_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // occasional ticks inside a command, may trip the watchdog
  task automatic maybe_ticks();
    if ($urandom_range(0, 99) < 20) repeat ($urandom_range(1, 4)) send_tick();
  endtask

  task automatic random_done();
    send_done($urandom_range(0, 99) < 20, $urandom_range(0, 99) < 10, 8'($urandom));
  endtask

  // one random command sequence, mostly well formed
  task automatic random_sequence();
    int unsigned pick;
    int unsigned len;
    int unsigned i;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // write transaction
      send_byte(s2icb_pkg::CH_START);
      maybe_ticks();
      send_byte({7'($urandom), 1'b0});
      if ($urandom_range(0, 99) < 85) random_done();
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      send_byte(8'(len));
      for (i = 0; i < len; i++) begin
        maybe_ticks();
        send_byte(8'($urandom));
        if ($urandom_range(0, 99) < 75) random_done();
      end
      if ($urandom_range(0, 99) < 80) send_byte(s2icb_pkg::CH_STOP);
    end else if (pick < 60) begin
      // read transaction
      send_byte(s2icb_pkg::CH_START);
      maybe_ticks();
      send_byte({7'($urandom), 1'b1});
      random_done();
      len = $urandom_range(1, 5);
      send_byte(8'(len));
      for (i = 0; i < len; i++) begin
        maybe_ticks();
        if ($urandom_range(0, 99) < 10) send_byte(8'($urandom));
        send_done(1'($urandom), $urandom_range(0, 99) < 10, 8'($urandom));
      end
      if ($urandom_range(0, 99) < 80) send_byte(s2icb_pkg::CH_STOP);
    end else if (pick < 68) begin
      send_byte(s2icb_pkg::CH_ERRORS);
    end else if (pick < 74) begin
      send_byte(s2icb_pkg::CH_STOP);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 6)) send_tick();
    end else if (pick < 90) begin
      send_link(1'($urandom), 1'($urandom));
    end else begin
      send_event(random_item());
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned target;
    logic [15:0] limits[4];

    in_ch.valid         = 1'b0;
    in_ch.cmd           = s2icb_pkg::EV_SERIAL;
    in_ch.data_byte     = '0;
    in_ch.bus_nack      = 1'b0;
    in_ch.bus_timeout   = 1'b0;
    in_ch.bus_read_data = '0;
    in_ch.link_overflow = 1'b0;
    in_ch.link_framing  = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    sent_count          = 0;
    in_no_gap           = 1'b0;
    out_no_stall        = 1'b0;

    // synchronous reset
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flag report, invalid commands, completion with nothing pending
    send_byte(s2icb_pkg::CH_ERRORS);
    send_byte(s2icb_pkg::CH_STOP);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_done(1'b0, 1'b1, 8'h00);
    send_link(1'b1, 1'b1);
    send_byte(s2icb_pkg::CH_ERRORS);

    // write with address nack, timeout masking nack, data nack
    send_byte(s2icb_pkg::CH_START);
    send_byte(8'hA0);
    send_done(1'b1, 1'b0, 8'h00);
    send_byte(8'd2);
    send_byte(8'hFF);
    send_done(1'b1, 1'b1, 8'hFF);
    send_byte(8'h00);
    send_done(1'b1, 1'b0, 8'h00);

    // repeated start into a read, serial byte and tick during the read
    send_byte(s2icb_pkg::CH_START);
    send_byte(8'hFF);
    send_done(1'b0, 1'b0, 8'h00);
    send_byte(8'd3);
    send_done(1'b0, 1'b0, 8'hFF);
    send_byte(8'h55);
    send_tick();
    send_done(1'b0, 1'b1, 8'hAA);
    send_done(1'b0, 1'b0, 8'h00);
    send_byte(s2icb_pkg::CH_STOP);

    // zero length, then stop and report
    send_byte(s2icb_pkg::CH_START);
    send_byte(8'h01);
    send_byte(8'd0);
    send_byte(s2icb_pkg::CH_STOP);
    send_byte(s2icb_pkg::CH_ERRORS);

    // watchdog at the shortest timeout
    write_timeout(16'd1);
    send_byte(s2icb_pkg::CH_START);
    send_tick();
    send_tick();
    send_byte(s2icb_pkg::CH_ERRORS);

    // random sequences under several timeouts
    limits[0] = 16'd3;
    limits[1] = 16'd0;
    limits[2] = 16'd1;
    limits[3] = 16'($urandom_range(2, 40));
    for (p = 0; p < 4; p++) begin
      write_timeout(limits[p]);
      in_no_gap    = (p == 1);
      out_no_stall = (p == 2);
      target = sent_count + 140;
      while (sent_count < target) random_sequence();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
